// ===== rtl/lraws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lraws_pkg: shared types and constants
// Command codes, controller states and the controller/datapath interface
// of the range-add weighted-sum block.
// ----------------------------------------------------------------------------
package lraws_pkg;

   localparam int LEAVES  = 1024;
   localparam int IDX_W   = $clog2(LEAVES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int START_W = 10;
   localparam int END_W   = 11;
   localparam int CFG_W   = 11;
   localparam int VAL_W   = 32;
   localparam int DATA_W  = 64;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_QRY_READ,
      ST_QRY_MUL,
      ST_QRY_ACC,
      ST_QRY_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_req;
      logic clear_wr;
      logic load_wr;
      logic sweep_init;
      logic rd;
      logic mul;
      logic acc;
      logic add_wr;
      logic idx_next;
      logic rsp_load;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    range_ok;
      logic    loaded_done;
      logic    load_ok;
      logic    sweep_last;
      logic    clear_last;
      logic    rsp_free;
   } sts_type;

endpackage

// ===== rtl/lraws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lraws_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lraws_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lraws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lraws_datapath: element store and arithmetic
// Holds the request, element memory, sweep index, multiplier and result.
// ----------------------------------------------------------------------------
module lraws_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  lraws_pkg::ctl_type              ctl,
   output lraws_pkg::sts_type              sts,
   input  logic [1:0]                      req_command,
   input  logic [lraws_pkg::START_W-1:0]   req_range_start,
   input  logic [lraws_pkg::END_W-1:0]     req_range_end,
   input  logic signed [lraws_pkg::VAL_W-1:0] req_value,
   input  logic                            csr_write_enable,
   input  logic [lraws_pkg::CFG_W-1:0]     csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [lraws_pkg::DATA_W-1:0] rsp_weighted_sum
);
   import lraws_pkg::*;

   cmd_type             cmd_ff;
   logic [START_W-1:0]  start_ff;
   logic [END_W-1:0]    end_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [CFG_W-1:0]    count_cfg_ff;
   logic [CNT_W-1:0]    loaded_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic [DATA_W-1:0]   prod_ff;
   logic [DATA_W-1:0]   acc_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_data_ff;

   logic [END_W-1:0]    end_clamped;
   logic [CNT_W-1:0]    eff_count;
   logic [CNT_W-1:0]    weight;
   logic [CNT_W-1:0]    idx_plus_one;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [DATA_W-1:0]   ram_wdata;
   logic [DATA_W-1:0]   ram_rdata;

   // clamp end of range to the leaf count
   assign end_clamped = (req_range_end > END_W'(LEAVES)) ? END_W'(LEAVES) : req_range_end;

   always_ff @(posedge clock) begin
      if (ctl.take_req) begin
         cmd_ff   <= cmd_type'(req_command);
         start_ff <= req_range_start;
         end_ff   <= end_clamped;
         value_ff <= {{(DATA_W-VAL_W){req_value[VAL_W-1]}}, req_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= CFG_W'(LEAVES);
      end else if (csr_write_enable) begin
         count_cfg_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (count_cfg_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (count_cfg_ff > CFG_W'(LEAVES)) begin
         eff_count = CNT_W'(LEAVES);
      end else begin
         eff_count = CNT_W'(count_cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (ctl.load_wr) begin
         loaded_ff <= loaded_ff + CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.sweep_init) begin
         idx_in = IDX_W'(start_ff);
      end else if (ctl.idx_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign idx_plus_one = {1'b0, idx_ff} + CNT_W'(1);
   assign weight       = idx_plus_one - CNT_W'(start_ff);

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= ram_rdata * {{(DATA_W-CNT_W){1'b0}}, weight};
      end
      if (ctl.sweep_init) begin
         acc_ff <= '0;
      end else if (ctl.acc) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // one write source per cycle: clearing pass, load, or add
   always_comb begin
      ram_we    = ctl.clear_wr | ctl.load_wr | ctl.add_wr;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      if (ctl.load_wr) begin
         ram_waddr = loaded_ff[IDX_W-1:0];
         ram_wdata = value_ff;
      end else if (ctl.add_wr) begin
         ram_wdata = ram_rdata + value_ff;
      end
   end

   lraws_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LEAVES)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ctl.rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weighted_sum = rsp_data_ff;

   always_comb begin
      sts.cmd         = cmd_ff;
      sts.range_ok    = END_W'(start_ff) < end_ff;
      sts.loaded_done = loaded_ff >= eff_count;
      sts.load_ok     = loaded_ff < eff_count;
      sts.sweep_last  = idx_plus_one == CNT_W'(end_ff);
      sts.clear_last  = idx_ff == IDX_W'(LEAVES - 1);
      sts.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== rtl/lraws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lraws_ctrl: sequencing state machine
// Runs the clearing pass, dispatches requests and steps element sweeps.
// ----------------------------------------------------------------------------
module lraws_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lraws_pkg::sts_type sts,
   output lraws_pkg::ctl_type ctl
);
   import lraws_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            unique case (sts.cmd)
               CMD_ADD: begin
                  if (sts.loaded_done && sts.range_ok) state_in = ST_ADD_READ;
               end
               CMD_QUERY: begin
                  if (sts.loaded_done) begin
                     state_in = sts.range_ok ? ST_QRY_READ : ST_QRY_DONE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ADD_READ:  state_in = ST_ADD_WRITE;
         ST_ADD_WRITE: state_in = sts.sweep_last ? ST_IDLE : ST_ADD_READ;
         ST_QRY_READ:  state_in = ST_QRY_MUL;
         ST_QRY_MUL:   state_in = ST_QRY_ACC;
         ST_QRY_ACC:   state_in = sts.sweep_last ? ST_QRY_DONE : ST_QRY_READ;
         ST_QRY_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_wr = 1'b1;
            ctl.idx_next = 1'b1;
         end
         ST_IDLE: begin
            req_stall    = 1'b0;
            ctl.take_req = req_valid;
         end
         ST_DISPATCH: begin
            ctl.load_wr    = (sts.cmd == CMD_LOAD) && sts.load_ok;
            ctl.sweep_init = ((sts.cmd == CMD_ADD) || (sts.cmd == CMD_QUERY))
                             && sts.loaded_done;
         end
         ST_ADD_READ: ctl.rd = 1'b1;
         ST_ADD_WRITE: begin
            ctl.add_wr   = 1'b1;
            ctl.idx_next = 1'b1;
         end
         ST_QRY_READ: ctl.rd  = 1'b1;
         ST_QRY_MUL:  ctl.mul = 1'b1;
         ST_QRY_ACC: begin
            ctl.acc      = 1'b1;
            ctl.idx_next = 1'b1;
         end
         ST_QRY_DONE: ctl.rsp_load = sts.rsp_free;
         default: ctl = '0;
      endcase
   end

endmodule

// ===== rtl/lazy_range_add_weighted_sum_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_range_add_weighted_sum_tree: range add / weighted range sum engine
// Keeps 1024 signed 64-bit elements; loads, adds over ranges, and returns
// sum of a[i]*(i-start+1) over [start, end), all modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (load, range add or query), taken when
//   req_valid is high and req_stall low. rsp_* carries one weighted sum per
//   accepted query after all elements are loaded, taken when rsp_valid is
//   high and rsp_stall low. csr_write_enable/csr_write_data set the element
//   count; write it only while the block is idle.
// Sequencing:
//   a load writes one element; a range add reads and writes each element of
//   the clamped range in turn; a query reads, multiplies and accumulates each
//   element in turn, then loads the result register. The element memory has
//   one read and one write port; one item is in work at a time.
// Reset:
//   a clearing pass zeroes all 1024 entries of the element memory, one entry
//   a cycle; req_stall stays high meanwhile.
// Stall:
//   a finished result waits in the output register; a new request is taken
//   meanwhile, and a following query holds at its end until the slot frees.
// ----------------------------------------------------------------------------
module lazy_range_add_weighted_sum_tree (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [lraws_pkg::START_W-1:0]       req_range_start,
   input  logic [lraws_pkg::END_W-1:0]         req_range_end,
   input  logic signed [lraws_pkg::VAL_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lraws_pkg::DATA_W-1:0] rsp_weighted_sum,
   input  logic                                csr_write_enable,
   input  logic [lraws_pkg::CFG_W-1:0]         csr_write_data
);
   import lraws_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequence requests
   lraws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // hold elements, compute sums
   lraws_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req_command),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weighted_sum (rsp_weighted_sum)
   );

   // only one memory write source in any cycle
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clear_wr, ctl.load_wr, ctl.add_wr}))
      else $error("multiple element memory writers");

   // an add write always follows its read
   a_add_after_read: assert property (@(posedge clock) disable iff (reset)
      ctl.add_wr |-> $past(ctl.rd))
      else $error("add write without preceding read");

   // never overwrite a result still waiting
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // no request taken during the clearing pass or a sweep
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.take_req |-> !(ctl.clear_wr || ctl.rd || ctl.acc))
      else $error("request taken while busy");

endmodule
